### rtl/mmd_pkg.sv
`timescale 1ns / 1ps

package mmd_pkg;

  // Message format
  localparam logic [31:0] MAGIC_WORD = 32'h59545543;
  localparam logic [62:0] SUM_MAX    = {63{1'b1}};

  // Configuration register reset values and decode
  localparam logic [31:0] MAX_PART_COUNT_RESET = 32'd65536;
  localparam logic [62:0] MAX_PART_SIZE_RESET  = 63'd1073741824;
  localparam int          PADDR_W              = 4;
  localparam int          PDATA_W              = 64;
  localparam logic        REG_MAX_PART_COUNT   = 1'b0;
  localparam logic        REG_MAX_PART_SIZE    = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DESCRIPTOR = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD    = 2'd1;
  localparam logic [1:0] KIND_STATUS     = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK              = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER      = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE        = 3'd2;
  localparam logic [2:0] ST_SIZE_OVERFLOW   = 3'd3;
  localparam logic [2:0] ST_LENGTH_MISMATCH = 3'd4;

  // Queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_COUNT,
    PH_SIZES,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  // One parsed byte: an optional descriptor or payload result, then an
  // optional final status
  typedef struct packed {
    logic        has_item;
    logic        item_payload;
    logic [31:0] part_index;
    logic [63:0] part_size;
    logic [62:0] payload_offset;
    logic [7:0]  payload_data;
    logic        has_status;
    logic [2:0]  status;
    logic [31:0] total_parts;
  } entry_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] part_index;
    logic [63:0] part_size;
    logic [62:0] payload_offset;
    logic [7:0]  payload_data;
    logic [2:0]  status;
    logic [31:0] total_parts;
    logic        end_of_message;
  } result_t;

endpackage

### rtl/mmd_if.sv
`timescale 1ns / 1ps

interface mmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface mmd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [31:0]        part_index;
  logic signed [63:0] part_size;
  logic [62:0]        payload_offset;
  logic [7:0]         payload_data;
  logic [2:0]         status;
  logic [31:0]        total_parts;
  logic               end_of_message;

  modport source (output valid, result_kind, part_index, part_size, payload_offset,
                  payload_data, status, total_parts, end_of_message, input ready);
  modport sink (input valid, result_kind, part_index, part_size, payload_offset,
                payload_data, status, total_parts, end_of_message, output ready);
endinterface

### rtl/multipart_message_deframer.sv
`timescale 1ns / 1ps
// Multipart message deframer.
// in_ch carries one message byte per transfer, last_byte marking the final
// one. Header: 32-bit magic, 32-bit part count, one signed 64-bit size per
// part, all little-endian. out_ch carries part descriptors, payload bytes
// with their offset, and one final status per message. Payload bytes go out
// before the status, so a consumer discards them when the status is not ok.
// A byte is taken every cycle while the four-entry queue between parser and
// output stage has room; its results pass through the queue and the output
// register to out_ch. A byte yields at most two results; the output stage
// sends one per cycle while the receiver is ready, so a final byte that also
// carries a descriptor or payload byte sends that result before its status.
// When the receiver stalls, the output register holds and the queue fills;
// in_ch.ready drops once the queue is full.
// Reset clears the parser, queue and output valid flag and restores the limit
// registers: max_part_count at 0x0, max_part_size at 0x8. The user writes
// them over APB only while the block is idle; the block does not enforce it.

module multipart_message_deframer (
  input  logic                         clk,
  input  logic                         rst,
  mmd_in_if.sink                       in_ch,
  mmd_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [mmd_pkg::PDATA_W-1:0]  pwdata,
  output logic [mmd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import mmd_pkg::*;

  logic [31:0] max_part_count;
  logic [62:0] max_part_size;
  logic        reg_sel;
  logic        cfg_write;

  logic        q_push;
  entry_t      q_push_entry;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  entry_t      q_head;

  // Decode register writes and reads
  assign pready    = 1'b1;
  assign reg_sel   = paddr[PADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_part_count <= MAX_PART_COUNT_RESET;
      max_part_size  <= MAX_PART_SIZE_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_MAX_PART_COUNT) begin
        max_part_count <= pwdata[31:0];
      end else begin
        max_part_size <= pwdata[62:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_MAX_PART_SIZE) begin
      prdata = {1'b0, max_part_size};
    end else begin
      prdata = {32'd0, max_part_count};
    end
  end

  mmd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .max_part_count (max_part_count),
    .max_part_size  (max_part_size),
    .q_full         (q_full),
    .push           (q_push),
    .push_entry     (q_push_entry)
  );

  mmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  mmd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

### rtl/mmd_front.sv
`timescale 1ns / 1ps

module mmd_front (
  input  logic            clk,
  input  logic            rst,
  mmd_in_if.sink          in_ch,
  input  logic [31:0]     max_part_count,
  input  logic [62:0]     max_part_size,
  input  logic            q_full,
  output logic            push,
  output mmd_pkg::entry_t push_entry
);
  import mmd_pkg::*;

  phase_t      phase, phase_step, phase_next;
  logic [2:0]  field_byte_count, cnt_step;
  logic [55:0] field_shift, shift_step;
  logic [31:0] header_part_count, hpc_step;
  logic [31:0] sizes_done, done_step;
  logic [62:0] payload_expected, pe_step;
  logic [63:0] payload_seen, seen_step;
  logic [2:0]  error_latch, err_step;

  logic        accept;
  logic        done4, done8;
  logic [31:0] word32;
  logic [63:0] word64;
  logic        size_neg, size_bad, size_ovf;
  logic [63:0] size_sum;
  logic [32:0] done_inc;
  logic        seen_below;
  entry_t      entry;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Assemble the field from the held bytes and the current one
  assign done4    = (field_byte_count == 3'd3);
  assign done8    = (field_byte_count == 3'd7);
  assign word32   = {in_ch.data_byte, field_shift[23:0]};
  assign word64   = {in_ch.data_byte, field_shift};
  assign size_neg = word64[63];
  assign size_bad = size_neg ? (word64 != {64{1'b1}}) : (word64[62:0] > max_part_size);
  assign size_sum = {1'b0, payload_expected} + {1'b0, word64[62:0]};
  assign size_ovf = !size_neg && size_sum[63];
  assign done_inc = {1'b0, sizes_done} + 33'd1;
  assign seen_below = (payload_seen < {1'b0, payload_expected});

  // Next phase
  always_comb begin
    case (phase)
      PH_MAGIC: begin
        if (!done4)                   phase_step = PH_MAGIC;
        else if (word32 != MAGIC_WORD) phase_step = PH_ERROR;
        else                          phase_step = PH_COUNT;
      end
      PH_COUNT: begin
        if (!done4)                        phase_step = PH_COUNT;
        else if (word32 > max_part_count)  phase_step = PH_ERROR;
        else if (word32 == 32'd0)          phase_step = PH_PAYLOAD;
        else                               phase_step = PH_SIZES;
      end
      PH_SIZES: begin
        if (!done8)                               phase_step = PH_SIZES;
        else if (size_bad || size_ovf)            phase_step = PH_ERROR;
        else if (done_inc >= {1'b0, hpc_step})    phase_step = PH_PAYLOAD;
        else                                      phase_step = PH_SIZES;
      end
      PH_PAYLOAD: phase_step = PH_PAYLOAD;
      PH_ERROR:   phase_step = PH_ERROR;
      default:    phase_step = PH_MAGIC;
    endcase
    phase_next = phase;
    if (accept) begin
      phase_next = in_ch.last_byte ? PH_MAGIC : phase_step;
    end
  end

  // Parse datapath and the entry for the queue
  always_comb begin
    cnt_step   = field_byte_count;
    shift_step = field_shift;
    hpc_step   = header_part_count;
    done_step  = sizes_done;
    pe_step    = payload_expected;
    seen_step  = payload_seen;
    err_step   = error_latch;
    entry      = '0;

    case (phase)
      PH_MAGIC, PH_COUNT: begin
        if (done4) begin
          cnt_step   = '0;
          shift_step = '0;
          if (phase == PH_COUNT) begin
            hpc_step = word32;
          end
          if ((phase == PH_MAGIC && word32 != MAGIC_WORD) ||
              (phase == PH_COUNT && word32 > max_part_count)) begin
            err_step = (error_latch != ST_OK) ? error_latch : ST_BAD_HEADER;
          end
        end else begin
          cnt_step = field_byte_count + 3'd1;
          shift_step[{field_byte_count, 3'b000} +: 8] = in_ch.data_byte;
        end
      end
      PH_SIZES: begin
        if (done8) begin
          cnt_step   = '0;
          shift_step = '0;
          if (size_bad) begin
            err_step = (error_latch != ST_OK) ? error_latch : ST_BAD_SIZE;
          end else if (size_ovf) begin
            pe_step  = SUM_MAX;
            err_step = (error_latch != ST_OK) ? error_latch : ST_SIZE_OVERFLOW;
          end else begin
            entry.has_item   = 1'b1;
            entry.part_index = sizes_done;
            entry.part_size  = word64;
            if (!size_neg) begin
              pe_step = size_sum[62:0];
            end
            done_step = done_inc[31:0];
          end
        end else begin
          cnt_step = field_byte_count + 3'd1;
          shift_step[{field_byte_count, 3'b000} +: 8] = in_ch.data_byte;
        end
      end
      PH_PAYLOAD: begin
        if (seen_below) begin
          entry.has_item       = 1'b1;
          entry.item_payload   = 1'b1;
          entry.payload_offset = payload_seen[62:0];
          entry.payload_data   = in_ch.data_byte;
        end
        if (payload_seen != {64{1'b1}}) begin
          seen_step = payload_seen + 64'd1;
        end
      end
      default: begin
      end
    endcase

    // Final status from the state this byte leaves behind
    if (in_ch.last_byte) begin
      entry.has_status  = 1'b1;
      entry.total_parts = hpc_step;
      if (err_step != ST_OK)
        entry.status = err_step;
      else if (phase_step == PH_MAGIC || phase_step == PH_COUNT)
        entry.status = ST_BAD_HEADER;
      else if (phase_step == PH_SIZES)
        entry.status = ST_BAD_SIZE;
      else if (seen_step != {1'b0, pe_step})
        entry.status = ST_LENGTH_MISMATCH;
      else
        entry.status = ST_OK;
    end
  end

  assign push       = accept && (entry.has_item || entry.has_status);
  assign push_entry = entry;

  // Advance parse state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_MAGIC;
      field_byte_count  <= '0;
      field_shift       <= '0;
      header_part_count <= '0;
      sizes_done        <= '0;
      payload_expected  <= '0;
      payload_seen      <= '0;
      error_latch       <= ST_OK;
    end else begin
      phase <= phase_next;
      if (accept) begin
        if (in_ch.last_byte) begin
          field_byte_count  <= '0;
          field_shift       <= '0;
          header_part_count <= '0;
          sizes_done        <= '0;
          payload_expected  <= '0;
          payload_seen      <= '0;
          error_latch       <= ST_OK;
        end else begin
          field_byte_count  <= cnt_step;
          field_shift       <= shift_step;
          header_part_count <= hpc_step;
          sizes_done        <= done_step;
          payload_expected  <= pe_step;
          payload_seen      <= seen_step;
          error_latch       <= err_step;
        end
      end
    end
  end

endmodule

### rtl/mmd_queue.sv
`timescale 1ns / 1ps

module mmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mmd_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output mmd_pkg::entry_t head
);
  import mmd_pkg::*;

  entry_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not follow push");

endmodule

### rtl/mmd_back.sv
`timescale 1ns / 1ps

module mmd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  mmd_pkg::entry_t head,
  output logic            pop,
  mmd_out_if.source       out_ch
);
  import mmd_pkg::*;

  logic    out_valid, out_valid_next;
  result_t out_res, out_res_next;
  logic    item_sent, item_sent_next;
  logic    load;

  assign load = !out_valid || out_ch.ready;

  // Unpack the head entry into one or two results
  always_comb begin
    out_valid_next = out_valid;
    out_res_next   = out_res;
    item_sent_next = item_sent;
    pop            = 1'b0;
    if (load) begin
      out_valid_next = !empty;
      if (!empty) begin
        out_res_next = '0;
        if (head.has_item && !item_sent) begin
          if (head.item_payload) begin
            out_res_next.result_kind    = KIND_PAYLOAD;
            out_res_next.payload_offset = head.payload_offset;
            out_res_next.payload_data   = head.payload_data;
          end else begin
            out_res_next.result_kind = KIND_DESCRIPTOR;
            out_res_next.part_index  = head.part_index;
            out_res_next.part_size   = head.part_size;
          end
          if (head.has_status) begin
            item_sent_next = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          out_res_next.result_kind    = KIND_STATUS;
          out_res_next.status         = head.status;
          out_res_next.total_parts    = head.total_parts;
          out_res_next.end_of_message = 1'b1;
          item_sent_next              = 1'b0;
          pop                         = 1'b1;
        end
      end
    end
  end

  // Hold the output register until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      item_sent <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      item_sent <= item_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    out_res <= out_res_next;
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.result_kind    = out_res.result_kind;
  assign out_ch.part_index     = out_res.part_index;
  assign out_ch.part_size      = out_res.part_size;
  assign out_ch.payload_offset = out_res.payload_offset;
  assign out_ch.payload_data   = out_res.payload_data;
  assign out_ch.status         = out_res.status;
  assign out_ch.total_parts    = out_res.total_parts;
  assign out_ch.end_of_message = out_res.end_of_message;

endmodule

### tb/sv/multipart_message_deframer_tb.sv
`timescale 1ns / 1ps

module multipart_message_deframer_tb;
  import mmd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL     = 300;
  localparam int SETTLE_CYCLES  = 12;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mmd_in_if  in_ch ();
  mmd_out_if out_ch ();

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  multipart_message_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  msg_byte_t pending_bytes[$];
  result_t   expected_results[$];
  int        fail_count = 0;
  bit        no_idle = 1'b0;
  bit        stall_armed = 1'b0;

  // Limit registers as the block should hold them
  logic [31:0] lim_part_count;
  logic [62:0] lim_part_size;

  // Parser state of the predictor
  phase_t      ph;
  int unsigned fld_count;
  logic [63:0] fld_shift;
  logic [31:0] hdr_count;
  logic [31:0] sizes_seen;
  logic [62:0] pay_expected;
  logic [63:0] pay_seen;
  logic [2:0]  err_code;

  function automatic void restart_message();
    ph           = PH_MAGIC;
    fld_count    = 0;
    fld_shift    = '0;
    hdr_count    = '0;
    sizes_seen   = '0;
    pay_expected = '0;
    pay_seen     = '0;
    err_code     = ST_OK;
  endfunction

  function automatic void latch_error(logic [2:0] code);
    if (err_code == ST_OK) err_code = code;
    ph = PH_ERROR;
  endfunction

  // Shift one byte into the current little-endian field; 1 when complete
  function automatic bit absorb_byte(logic [7:0] b, int unsigned width);
    fld_shift = fld_shift | (64'(b) << (8 * (fld_count % 8)));
    fld_count++;
    if (fld_count >= width) begin
      fld_count = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the results that one accepted byte causes
  function automatic void deframe_byte(logic [7:0] b, logic last);
    logic [63:0] raw;
    result_t     r;
    case (ph)
      PH_MAGIC: begin
        if (absorb_byte(b, 4)) begin
          if (fld_shift != {32'h0, MAGIC_WORD}) latch_error(ST_BAD_HEADER);
          else ph = PH_COUNT;
          fld_shift = '0;
        end
      end
      PH_COUNT: begin
        if (absorb_byte(b, 4)) begin
          hdr_count = fld_shift[31:0];
          fld_shift = '0;
          if (hdr_count > lim_part_count) latch_error(ST_BAD_HEADER);
          else ph = (hdr_count == 0) ? PH_PAYLOAD : PH_SIZES;
        end
      end
      PH_SIZES: begin
        if (absorb_byte(b, 8)) begin
          raw = fld_shift;
          fld_shift = '0;
          if (raw[63] ? (raw != '1) : (raw > {1'b0, lim_part_size})) begin
            latch_error(ST_BAD_SIZE);
          end else if (!raw[63] && raw != 0 &&
                       {1'b0, pay_expected} > {1'b0, SUM_MAX} - raw) begin
            pay_expected = SUM_MAX;
            latch_error(ST_SIZE_OVERFLOW);
          end else begin
            if (!raw[63]) pay_expected = pay_expected + raw[62:0];
            r = '0;
            r.result_kind = KIND_DESCRIPTOR;
            r.part_index  = sizes_seen;
            r.part_size   = raw;
            expected_results = {expected_results, r};
            sizes_seen++;
            if (sizes_seen >= hdr_count) ph = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pay_seen < {1'b0, pay_expected}) begin
          r = '0;
          r.result_kind    = KIND_PAYLOAD;
          r.payload_offset = pay_seen[62:0];
          r.payload_data   = b;
          expected_results = {expected_results, r};
        end
        if (pay_seen != '1) pay_seen++;
      end
      default: ;
    endcase

    if (last) begin
      r = '0;
      r.result_kind    = KIND_STATUS;
      r.total_parts    = hdr_count;
      r.end_of_message = 1'b1;
      if (err_code != ST_OK) r.status = err_code;
      else if (ph == PH_MAGIC || ph == PH_COUNT) r.status = ST_BAD_HEADER;
      else if (ph == PH_SIZES) r.status = ST_BAD_SIZE;
      else if (pay_seen != {1'b0, pay_expected}) r.status = ST_LENGTH_MISMATCH;
      else r.status = ST_OK;
      expected_results = {expected_results, r};
      restart_message();
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Input driver: predict on each transfer, then offer the next byte
  int        tx_gap;
  msg_byte_t tx_next;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
      tx_gap          <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.data_byte, in_ch.last_byte);
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered byte
      end else if (tx_gap > 0) begin
        in_ch.valid <= 1'b0;
        tx_gap      <= tx_gap - 1;
      end else if (!no_idle && pending_bytes.size() > 0 && $urandom_range(0, 9) == 0) begin
        in_ch.valid <= 1'b0;
        tx_gap      <= $urandom_range(0, 16);
      end else if (pending_bytes.size() > 0) begin
        tx_next = pending_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= tx_next.data;
        in_ch.last_byte <= tx_next.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed once
  int stall_left;
  bit stall_used;

  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_used <= 1'b0;
    end else if (stall_armed && !stall_used) begin
      stall_left <= LONG_STALL;
      stall_used <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Output monitor: compare each transfer with the oldest expectation
  int      rx_gap;
  result_t got_want;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_gap       <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result_kind %0d arrived with nothing expected", out_ch.result_kind);
          fail_count++;
        end else begin
          got_want = expected_results.pop_front();
          check_field("result_kind", 64'(got_want.result_kind), 64'(out_ch.result_kind));
          check_field("part_index", 64'(got_want.part_index), 64'(out_ch.part_index));
          check_field("part_size", got_want.part_size, out_ch.part_size);
          check_field("payload_offset", 64'(got_want.payload_offset),
                      64'(out_ch.payload_offset));
          check_field("payload_data", 64'(got_want.payload_data), 64'(out_ch.payload_data));
          check_field("status", 64'(got_want.status), 64'(out_ch.status));
          check_field("total_parts", 64'(got_want.total_parts), 64'(out_ch.total_parts));
          check_field("end_of_message", 64'(got_want.end_of_message),
                      64'(out_ch.end_of_message));
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        out_ch.ready <= 1'b0;
        rx_gap       <= rx_gap - 1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        rx_gap       <= $urandom_range(0, 16);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles without any transfer
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("multipart_message_deframer_tb: FAIL");
    $finish;
  end

  // Stimulus helpers
  function automatic void push_byte(logic [7:0] data, logic last);
    msg_byte_t m;
    m.data = data;
    m.last = last;
    pending_bytes = {pending_bytes, m};
  endfunction

  function automatic void push_field(logic [63:0] value, int nbytes, logic last_on_end);
    for (int k = 0; k < nbytes; k++) push_byte(value[8*k +: 8], last_on_end && k == nbytes - 1);
  endfunction

  function automatic logic [63:0] pick_size();
    int          sel;
    logic [62:0] cap;
    logic [63:0] v;
    sel = $urandom_range(0, 99);
    cap = (lim_part_size < 6) ? lim_part_size : 63'd6;
    if (sel < 60) return 64'($urandom_range(0, int'(cap)));
    if (sel < 72) return '1;
    if (sel < 78) return {1'b0, lim_part_size};
    if (sel < 84 && lim_part_size != SUM_MAX) return {1'b0, lim_part_size} + 64'd1;
    if (sel < 90) begin
      // negative but not the null marker
      v = {1'b1, 31'($urandom), 32'($urandom)};
      if (v == '1) v = {1'b1, 63'd0};
      return v;
    end
    return {1'b0, 31'($urandom), 32'($urandom)};
  endfunction

  // One message: mostly well formed, sometimes corrupted or cut short
  task automatic queue_message();
    logic [7:0]  msg[$];
    logic [31:0] magic;
    logic [31:0] count;
    logic [63:0] sz;
    logic [63:0] sum;
    bit          huge;
    int          parts;
    int          pay_len;
    int          cut;
    int          sel;
    magic = MAGIC_WORD;
    if ($urandom_range(0, 9) == 0) magic = magic ^ (32'h1 << $urandom_range(0, 31));
    sel = $urandom_range(0, 99);
    if (sel < 85) count = $urandom_range(0, 4);
    else if (sel < 93 && lim_part_count != '1) count = lim_part_count + 1;
    else count = $urandom;
    for (int k = 0; k < 4; k++) msg = {msg, magic[8*k +: 8]};
    for (int k = 0; k < 4; k++) msg = {msg, count[8*k +: 8]};
    sum   = '0;
    huge  = 1'b0;
    parts = (count > 5) ? 5 : int'(count);
    for (int p = 0; p < parts; p++) begin
      sz = pick_size();
      for (int k = 0; k < 8; k++) msg = {msg, sz[8*k +: 8]};
      if (!sz[63]) begin
        if (sz > 40) huge = 1'b1;
        else sum = sum + sz;
      end
    end
    if (sum > 40) huge = 1'b1;
    sel = $urandom_range(0, 99);
    if (huge) pay_len = $urandom_range(0, 8);
    else if (sel < 70 || sum == 0 && sel < 85) pay_len = int'(sum);
    else if (sel < 85) pay_len = int'(sum) - $urandom_range(1, int'(sum));
    else pay_len = int'(sum) + $urandom_range(1, 3);
    for (int k = 0; k < pay_len; k++) msg = {msg, 8'($urandom)};
    cut = msg.size();
    if ($urandom_range(0, 11) == 0) cut = $urandom_range(1, msg.size() - 1);
    for (int k = 0; k < cut; k++) push_byte(msg[k], k == cut - 1);
  endtask

  // Random bytes with stray end marks
  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++)
      push_byte(8'($urandom), (k == n - 1) || ($urandom_range(0, 7) == 0));
  endtask

  task automatic queue_random(int budget);
    int target;
    target = pending_bytes.size() + budget;
    while (pending_bytes.size() < target) begin
      if ($urandom_range(0, 99) < 85) queue_message();
      else queue_noise();
    end
  endtask

  // Wait until every byte is in and every result is out, then let the pipe settle
  task automatic drain();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limits(logic [31:0] part_count, logic [62:0] part_size);
    apb_write(PADDR_W'({REG_MAX_PART_COUNT, 3'b000}), {32'h0, part_count});
    apb_write(PADDR_W'({REG_MAX_PART_SIZE, 3'b000}), {1'b0, part_size});
    lim_part_count = part_count;
    lim_part_size  = part_size;
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    lim_part_count  = MAX_PART_COUNT_RESET;
    lim_part_size   = MAX_PART_SIZE_RESET;
    restart_message();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: end inside magic, bad magic with an ignored byte,
    // extra payload byte, empty message ending on the count
    push_byte(8'h00, 1'b1);
    push_field(64'hFFFF_FFFF, 4, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_field({32'h0, MAGIC_WORD}, 4, 1'b0);
    push_field(64'h0, 4, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_field({32'h0, MAGIC_WORD}, 4, 1'b0);
    push_field(64'h0, 4, 1'b1);
    drain();

    // Reset limits, with one long receiver hold-off
    queue_random(400);
    stall_armed = 1'b1;
    drain();

    // Tightest limits
    set_limits(32'h0, 63'h0);
    queue_random(250);
    drain();

    // Small limits that messages reach and exceed
    set_limits(32'd3, 63'd5);
    queue_random(300);
    drain();

    // Widest limits: huge sizes and payload sum overflow
    set_limits('1, SUM_MAX);
    queue_random(400);
    drain();

    // Back to reset values, full rate on both sides
    set_limits(MAX_PART_COUNT_RESET, MAX_PART_SIZE_RESET);
    no_idle = 1'b1;
    queue_random(150);
    drain();

    if (fail_count == 0) begin
      $display("multipart_message_deframer_tb: PASS");
    end else begin
      $display("multipart_message_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule
